[rtl/rtpts_pkg.sv]
// ----------------------------------------------------------------------------
// rtpts_pkg
// Shared types, codes and constants for the RTP / transport stream PCR
// extractor and stream classifier.
// ----------------------------------------------------------------------------
package rtpts_pkg;

	// rtp header length default and transport packet size
	localparam int RTP_HDR_BYTES_DEF = 12;
	localparam int TS_PACKET_BYTES   = 188;
	localparam int TS_POS_W          = 8;

	// byte positions inside a transport packet
	localparam logic [TS_POS_W-1:0] POS_SYNC      = 8'd0;
	localparam logic [TS_POS_W-1:0] POS_PID_HI    = 8'd1;
	localparam logic [TS_POS_W-1:0] POS_PID_LO    = 8'd2;
	localparam logic [TS_POS_W-1:0] POS_PCR_FIRST = 8'd6;
	localparam logic [TS_POS_W-1:0] POS_PCR_LAST  = 8'd11;
	localparam logic [TS_POS_W-1:0] POS_TS_LAST   = 8'(TS_PACKET_BYTES - 1);

	// pid and configuration
	localparam int PID_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PCR_PID   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_PID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_PID = 2'd2;
	localparam logic [PID_W-1:0] PCR_PID_RST   = 13'h1000;
	localparam logic [PID_W-1:0] VIDEO_PID_RST = 13'h1011;
	localparam logic [PID_W-1:0] AUDIO_PID_RST = 13'h1100;

	// media kind codes
	localparam logic [1:0] KIND_AUDIO = 2'd0;
	localparam logic [1:0] KIND_VIDEO = 2'd1;
	localparam logic [1:0] KIND_NONE  = 2'd2;

	// pcr search progress
	typedef enum logic [1:0] {
		SEARCHING = 2'd0,
		CAPTURING = 2'd1,
		DONE      = 2'd2
	} pcr_search_t;

	// pcr field layout and conversion constants
	localparam int PCR_BITS  = 48;
	localparam int BASE_W    = 33;
	localparam int EXT_W     = 9;
	localparam int MS_W      = 27;
	// base/90 is worked as (base>>1)/45 by a reciprocal multiply
	localparam int            RECIP_SHIFT = 37;
	localparam logic [31:0]   RECIP_45    = 32'd3054198966;
	localparam logic [31:0]   DIV_45      = 32'd45;
	localparam logic [6:0]    REM_45      = 7'd45;
	localparam logic [14:0]   MUL_300     = 15'd300;
	localparam logic [14:0]   TICKS_27000 = 15'd27000;

	// queue between parser and converter
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int QUEUE_CNT_W = 3;

	// input word: one packet byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} pkt_word_t;

	// result word: one per rtp packet
	typedef struct packed {
		logic            pcr_valid;
		logic [MS_W-1:0] pcr_ms;
		logic [1:0]      media_kind;
		logic            malformed;
	} res_word_t;

	// per-packet summary handed from parser to converter
	typedef struct packed {
		logic              pcr_done;
		logic [BASE_W-1:0] base_90k;
		logic [EXT_W-1:0]  pcr_ext;
		logic [1:0]        media_kind;
		logic              malformed;
	} rec_t;

endpackage

[rtl/rtpts_front.sv]
// ----------------------------------------------------------------------------
// rtpts_front
// Byte parser: skips the rtp header, walks transport packets, captures the
// first pcr field, sets the media kind and emits one summary per rtp packet.
// ----------------------------------------------------------------------------
module rtpts_front
	import rtpts_pkg::*;
#(
	parameter int RTP_HEADER_BYTES = RTP_HDR_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pkt_valid,
	output logic                 pkt_stall,
	input  pkt_word_t            pkt_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PID_W-1:0]     cfg_data,
	output logic                 push,
	output rec_t                 rec,
	input  logic                 full
);

	localparam int HCW = $clog2(RTP_HEADER_BYTES + 1);

	logic [PID_W-1:0] pcr_pid_q, video_pid_q, audio_pid_q;

	logic [HCW-1:0]      hdr_q, hdr_n;
	logic [TS_POS_W-1:0] pos_q, pos_n;
	logic                seen_q, seen_n;
	logic [4:0]          pidhi_q, pidhi_n;
	logic                is_pcr_q, is_pcr_n;
	logic [PCR_BITS-1:0] shift_q, shift_n;
	pcr_search_t         search_q, search_n;
	logic [1:0]          kind_q, kind_n;

	logic             acc, in_hdr, packet_end;
	logic [PID_W-1:0] pid;

	assign cfg_ready = 1'b1;
	assign pkt_stall = full;
	assign acc       = pkt_valid && !pkt_stall;
	assign push      = acc && pkt_word.last_byte;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcr_pid_q   <= PCR_PID_RST;
			video_pid_q <= VIDEO_PID_RST;
			audio_pid_q <= AUDIO_PID_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PCR_PID:   pcr_pid_q   <= cfg_data;
				CFG_VIDEO_PID: video_pid_q <= cfg_data;
				CFG_AUDIO_PID: audio_pid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next parse state for the byte on the port
	always_comb begin
		hdr_n      = hdr_q;
		pos_n      = pos_q;
		seen_n     = seen_q;
		pidhi_n    = pidhi_q;
		is_pcr_n   = is_pcr_q;
		shift_n    = shift_q;
		search_n   = search_q;
		kind_n     = kind_q;
		pid        = {pidhi_q, pkt_word.data_byte};
		in_hdr     = hdr_q < HCW'(RTP_HEADER_BYTES);
		packet_end = 1'b0;
		if (in_hdr) begin
			hdr_n = hdr_q + 1'b1;
		end else begin
			seen_n = 1'b1;
			if (pos_q == POS_SYNC) is_pcr_n = 1'b0;
			if (pos_q == POS_PID_HI) pidhi_n = pkt_word.data_byte[4:0];
			if (pos_q == POS_PID_LO) begin
				if (search_q == SEARCHING && pid == pcr_pid_q) begin
					search_n = CAPTURING;
					is_pcr_n = 1'b1;
				end
				if (kind_q == KIND_NONE) begin
					if (pid == video_pid_q) kind_n = KIND_VIDEO;
					else if (pid == audio_pid_q) kind_n = KIND_AUDIO;
				end
			end
			if (is_pcr_n && pos_q >= POS_PCR_FIRST && pos_q <= POS_PCR_LAST) begin
				shift_n = {shift_q[PCR_BITS-9:0], pkt_word.data_byte};
				if (pos_q == POS_PCR_LAST) begin
					search_n = DONE;
					is_pcr_n = 1'b0;
				end
			end
			packet_end = pos_q >= POS_TS_LAST;
			pos_n      = packet_end ? '0 : pos_q + 1'b1;
		end
	end

	// summary of the packet as it stands after its last byte
	always_comb begin
		rec.pcr_done   = search_n == DONE;
		rec.base_90k   = shift_n[PCR_BITS-1 -: BASE_W];
		rec.pcr_ext    = shift_n[EXT_W-1:0];
		rec.media_kind = kind_n;
		rec.malformed  = !(seen_n && packet_end);
	end

	// parse state, cleared after every last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= '0;
			pos_q    <= '0;
			seen_q   <= 1'b0;
			pidhi_q  <= '0;
			is_pcr_q <= 1'b0;
			shift_q  <= '0;
			search_q <= SEARCHING;
			kind_q   <= KIND_NONE;
		end else if (acc) begin
			if (pkt_word.last_byte) begin
				hdr_q    <= '0;
				pos_q    <= '0;
				seen_q   <= 1'b0;
				pidhi_q  <= '0;
				is_pcr_q <= 1'b0;
				shift_q  <= '0;
				search_q <= SEARCHING;
				kind_q   <= KIND_NONE;
			end else begin
				hdr_q    <= hdr_n;
				pos_q    <= pos_n;
				seen_q   <= seen_n;
				pidhi_q  <= pidhi_n;
				is_pcr_q <= is_pcr_n;
				shift_q  <= shift_n;
				search_q <= search_n;
				kind_q   <= kind_n;
			end
		end
	end

`ifndef SYNTHESIS
	// the capture is always closed by the time the search is marked done
	a_done_not_capturing: assert property (@(posedge clk) disable iff (!arst_n)
		(search_q == DONE) |-> !is_pcr_q)
		else $error("pcr capture still open after search done");
`endif

endmodule

[rtl/rtpts_queue.sv]
// ----------------------------------------------------------------------------
// rtpts_queue
// Short first-in first-out queue of packet summaries between the parser and
// the pcr converter.
// ----------------------------------------------------------------------------
module rtpts_queue
	import rtpts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	output logic nonempty,
	input  logic pop,
	output rec_t pop_rec
);

	rec_t                   mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;

	assign full     = cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH);
	assign nonempty = cnt_q != '0;
	assign pop_rec  = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_rec;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	// parser must hold off while the queue is full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("word pushed into full queue");
	// converter only pops a held word
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("word popped from empty queue");
	// count tracks pointer distance
	a_cnt_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[QUEUE_PTR_W-1:0] == QUEUE_PTR_W'(wr_ptr_q - rd_ptr_q))
		else $error("queue count out of step with pointers");
`endif

endmodule

[rtl/rtpts_pcr_conv.sv]
// ----------------------------------------------------------------------------
// rtpts_pcr_conv
// Four-stage pipeline turning base*300+ext into milliseconds, worked as
// base/90 by reciprocal multiply plus a remainder correction.
// ----------------------------------------------------------------------------
module rtpts_pcr_conv
	import rtpts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rec_valid,
	output logic      rec_pop,
	input  rec_t      rec,
	output logic      res_valid,
	input  logic      res_stall,
	output res_word_t res_word
);

	logic rdy1, rdy2, rdy3, rdy4;
	logic v_s1, v_s2, v_s3;

	// sideband carried along the pipe
	logic             done_s1, done_s2, done_s3;
	logic [EXT_W-1:0] ext_s1, ext_s2, ext_s3;
	logic [1:0]       kind_s1, kind_s2, kind_s3;
	logic             mal_s1, mal_s2, mal_s3;
	logic             b0_s1, b0_s2;

	logic [31:0]     c_s1;
	logic [63:0]     prod_s1;
	logic [MS_W-1:0] q_s2, q_s3;
	logic [6:0]      rem_s2, m_s3;

	logic [31:0]     c_in;
	logic [MS_W-1:0] q_est;
	logic [31:0]     rem32;
	logic [14:0]     t_frac;
	logic [MS_W-1:0] ms;

	// stage advance chain
	assign rdy4    = !res_valid || !res_stall;
	assign rdy3    = !v_s3 || rdy4;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign rec_pop = rec_valid && rdy1;

	assign c_in  = rec.base_90k[BASE_W-1:1];
	assign q_est = prod_s1[63:RECIP_SHIFT];
	assign rem32 = c_s1 - ({5'b0, q_est} * DIV_45);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= rec_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) res_valid <= v_s3;
		end
	end

	// stage 1: reciprocal product of base/2
	always_ff @(posedge clk) begin
		if (rdy1) begin
			c_s1    <= c_in;
			prod_s1 <= 64'(c_in) * 64'(RECIP_45);
			b0_s1   <= rec.base_90k[0];
			done_s1 <= rec.pcr_done;
			ext_s1  <= rec.pcr_ext;
			kind_s1 <= rec.media_kind;
			mal_s1  <= rec.malformed;
		end
	end

	// stage 2: estimated quotient and raw remainder
	always_ff @(posedge clk) begin
		if (rdy2) begin
			q_s2    <= q_est;
			rem_s2  <= rem32[6:0];
			b0_s2   <= b0_s1;
			done_s2 <= done_s1;
			ext_s2  <= ext_s1;
			kind_s2 <= kind_s1;
			mal_s2  <= mal_s1;
		end
	end

	// stage 3: one-step correction, remainder modulo 90
	always_ff @(posedge clk) begin
		if (rdy3) begin
			if (rem_s2 >= REM_45) begin
				q_s3 <= q_s2 + 1'b1;
				m_s3 <= {6'(rem_s2 - REM_45), b0_s2};
			end else begin
				q_s3 <= q_s2;
				m_s3 <= {rem_s2[5:0], b0_s2};
			end
			done_s3 <= done_s2;
			ext_s3  <= ext_s2;
			kind_s3 <= kind_s2;
			mal_s3  <= mal_s2;
		end
	end

	// stage 4: carry of the leftover ticks, result register
	always_comb begin
		t_frac = ({8'b0, m_s3} * MUL_300) + {6'b0, ext_s3};
		ms     = done_s3 ? (q_s3 + MS_W'(t_frac >= TICKS_27000)) : '0;
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			res_word.pcr_valid  <= ms != '0;
			res_word.pcr_ms     <= ms;
			res_word.media_kind <= kind_s3;
			res_word.malformed  <= mal_s3;
		end
	end

`ifndef SYNTHESIS
	// reciprocal estimate is never more than one short
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (rem_s2 < 7'd90))
		else $error("quotient estimate off by more than one");
`endif

endmodule

[rtl/rtp_ts_pcr_and_stream_classifier.sv]
// ----------------------------------------------------------------------------
// rtp_ts_pcr_and_stream_classifier
// Path: a summary passes the queue, converter stages 1 to 3, result register.
// Throughput: one byte per cycle unless the 4-word summary queue is full;
// up to one result per cycle unless res_stall, via the four-stage converter.
// Reset: asynchronous, clears parse state, queue and pipeline valid bits and
// loads the pid registers with their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module rtp_ts_pcr_and_stream_classifier
	import rtpts_pkg::*;
#(
	parameter int RTP_HEADER_BYTES = RTP_HDR_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pkt_valid,
	output logic                 pkt_stall,
	input  pkt_word_t            pkt_word,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_word_t            res_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PID_W-1:0]     cfg_data
);

	logic push, full, nonempty, pop;
	rec_t push_rec, pop_rec;

	// parser front
	rtpts_front #(
		.RTP_HEADER_BYTES(RTP_HEADER_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt_word  (pkt_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.rec       (push_rec),
		.full      (full)
	);

	// summary queue
	rtpts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (full),
		.nonempty (nonempty),
		.pop      (pop),
		.pop_rec  (pop_rec)
	);

	// millisecond converter back end
	rtpts_pcr_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (nonempty),
		.rec_pop   (pop),
		.rec       (pop_rec),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule
